// ===== rtl/tsfm_pkg.sv =====
// Shared types and constants for the touch sample filter and mapper.
// No dependencies; tsfm_map, tsfm_core and the top level in rtl/ import this package.
package tsfm_pkg;

    // Default parameter values
    localparam int SAMPLES_DEF     = 5;
    localparam int TRIM_DEF        = 1;
    localparam int SAMPLE_BITS_DEF = 12;

    // Fixed field widths
    localparam int IN_W      = 12;
    localparam int COORD_W   = 16;
    localparam int REG_W     = 32;
    localparam int TOL_W     = 12;
    localparam int CFG_IDX_W = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_AXES   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_AGREE_TOL   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X     = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y     = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = CFG_IDX_W'(6);

    // Register reset values
    localparam logic [TOL_W-1:0] TOL_RST    = TOL_W'(50);
    localparam logic [REG_W-1:0] SCALE_RST  = REG_W'(65536);
    localparam logic [REG_W-1:0] OFFSET_RST = '0;

    typedef struct packed {
        logic             screen_mode;
        logic             swap_axes;
        logic [TOL_W-1:0] agree_tolerance;
        logic [REG_W-1:0] scale_x;
        logic [REG_W-1:0] scale_y;
        logic [REG_W-1:0] offset_x;
        logic [REG_W-1:0] offset_y;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic               coord_valid;
        logic               touched;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RANK,
        ST_ACC,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_JUDGE,
        ST_MAP_GO,
        ST_MAP_WAIT,
        ST_EMIT
    } state_t;

endpackage

// ===== rtl/tsfm_div.sv =====
// Divide by the constant kept count through one registered reciprocal multiply;
// done is asserted in the cycle after start. Depends on nothing but its parameters.
module tsfm_div #(
    parameter int SUMW = 15,
    parameter int KEPT = 3,
    parameter int QW   = 12
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [SUMW-1:0] dividend,
    output logic            done,
    output logic [QW-1:0]   quotient
);
    // floor(n * RECIP / 2**SH) equals floor(n / KEPT) for every SUMW-bit n,
    // as the rounding error of RECIP times n stays below 2**SH
    localparam int SH = SUMW + $clog2(KEPT);
    localparam int MW = SH + 1;
    localparam int PW = SUMW + MW;
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SH) + 64'(KEPT) - 64'd1) / 64'(KEPT));

    logic [PW-1:0] prod_reg;
    logic          done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= PW'(dividend) * PW'(RECIP);
        end
    end

    assign done     = done_reg;
    assign quotient = prod_reg[SH +: QW];

endmodule

// ===== rtl/tsfm_map.sv =====
// Affine calibration: Q16.16 scale times averaged ADC value plus offset,
// floored and saturated to 0..65535. Multiply and add are registered apart.
module tsfm_map #(
    parameter int AW = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [AW-1:0]                 avg,
    input  logic [tsfm_pkg::REG_W-1:0]    scale,
    input  logic [tsfm_pkg::REG_W-1:0]    offset,
    output logic                          done,
    output logic [tsfm_pkg::COORD_W-1:0]  result
);
    import tsfm_pkg::*;

    localparam int PW = REG_W + AW + 1;
    localparam int SW = PW + 1;

    logic signed [REG_W-1:0] scale_s;
    logic signed [AW:0]      avg_s;
    logic signed [PW-1:0]    prod_reg;
    logic        [SW-1:0]    acc;
    logic        [COORD_W-1:0] sat;
    logic        [COORD_W-1:0] result_reg;
    logic                    mul_vld_reg;
    logic                    done_reg;

    assign scale_s = $signed(scale);
    assign avg_s   = $signed({1'b0, avg});

    always_comb
    begin
        acc = {prod_reg[PW-1], prod_reg} + {{(SW - REG_W){offset[REG_W-1]}}, offset};
        if (acc[SW-1])
        begin
            sat = '0;
        end
        else if (|acc[SW-2:REG_W])
        begin
            sat = '1;
        end
        else
        begin
            sat = acc[REG_W-1:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            mul_vld_reg <= start;
            done_reg    <= mul_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= scale_s * avg_s;
        end
        if (mul_vld_reg)
        begin
            result_reg <= sat;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/tsfm_core.sv =====
// Sequencer and datapath: sample store, rank-based trimmed sum through one
// shared comparator and adder, agreement check. Uses tsfm_div and tsfm_map.
module tsfm_core #(
    parameter int SAMPLES     = tsfm_pkg::SAMPLES_DEF,
    parameter int TRIM        = tsfm_pkg::TRIM_DEF,
    parameter int SAMPLE_BITS = tsfm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      pen_down,
    input  logic [tsfm_pkg::IN_W-1:0] sample_x,
    input  logic [tsfm_pkg::IN_W-1:0] sample_y,
    input  tsfm_pkg::cfg_t            cfg,
    input  logic                      out_free,
    output logic                      emit,
    output tsfm_pkg::res_t            res
);
    import tsfm_pkg::*;

    localparam int EFF_TRIM = (2 * TRIM >= SAMPLES) ? (SAMPLES - 1) / 2 : TRIM;
    localparam int KEPT     = SAMPLES - 2 * EFF_TRIM;
    localparam int CNTW     = $clog2(SAMPLES);
    localparam int SUMW     = SAMPLE_BITS + $clog2(SAMPLES);
    localparam int CMPW     = (SAMPLE_BITS > TOL_W) ? SAMPLE_BITS : TOL_W;
    localparam logic [CNTW-1:0] LAST_IDX = CNTW'(SAMPLES - 1);
    localparam logic [CNTW:0]   KEEP_LO  = (CNTW + 1)'(EFF_TRIM);
    localparam logic [CNTW:0]   KEEP_HI  = (CNTW + 1)'(SAMPLES - EFF_TRIM);

    state_t state_reg, state_next;

    logic [SAMPLE_BITS-1:0] x_mem [SAMPLES];
    logic [SAMPLE_BITS-1:0] y_mem [SAMPLES];

    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [CNTW-1:0] i_reg, i_next;
    logic [CNTW-1:0] j_reg, j_next;
    logic [CNTW-1:0] rank_reg, rank_next;
    logic [CNTW-1:0] rd_idx;
    logic            second_reg, second_next;
    logic            axis_reg, axis_next;
    logic            map_axis_reg, map_axis_next;
    logic [SAMPLE_BITS-1:0] fmx_reg, fmx_next, fmy_reg, fmy_next;
    logic [SAMPLE_BITS-1:0] mx_reg, mx_next, my_reg, my_next;
    logic [SAMPLE_BITS-1:0] cur_reg, cur_next;
    logic [SAMPLE_BITS-1:0] rd_data, wr_x, wr_y;
    logic [SUMW-1:0]        sum_reg, sum_next;
    res_t                   res_reg, res_next;

    logic accept, last_sample, less, in_keep;
    logic div_start, div_done, map_start, map_done;
    logic [SAMPLE_BITS-1:0] div_q, map_avg;
    logic [REG_W-1:0]       map_scale, map_offset;
    logic [COORD_W-1:0]     map_res;
    logic [SAMPLE_BITS-1:0] diff_x, diff_y, avg_x, avg_y;
    logic [SAMPLE_BITS:0]   pair_x, pair_y;
    logic                   agree_ok;

    assign accept      = in_valid & in_ready;
    assign last_sample = (cnt_reg == LAST_IDX);

    assign wr_x = cfg.swap_axes ? SAMPLE_BITS'(sample_y) : SAMPLE_BITS'(sample_x);
    assign wr_y = cfg.swap_axes ? SAMPLE_BITS'(sample_x) : SAMPLE_BITS'(sample_y);

    always_ff @(posedge clk)
    begin
        if (accept && pen_down)
        begin
            x_mem[cnt_reg] <= wr_x;
            y_mem[cnt_reg] <= wr_y;
        end
    end

    assign rd_idx  = (state_reg == ST_LOAD) ? i_reg : j_reg;
    assign rd_data = axis_reg ? y_mem[rd_idx] : x_mem[rd_idx];

    // equal values are ranked by position so ranks form a permutation
    assign less    = (rd_data < cur_reg) || ((rd_data == cur_reg) && (j_reg < i_reg));
    assign in_keep = ({1'b0, rank_reg} >= KEEP_LO) && ({1'b0, rank_reg} < KEEP_HI);

    assign diff_x   = (fmx_reg > mx_reg) ? fmx_reg - mx_reg : mx_reg - fmx_reg;
    assign diff_y   = (fmy_reg > my_reg) ? fmy_reg - my_reg : my_reg - fmy_reg;
    assign agree_ok = (CMPW'(diff_x) < CMPW'(cfg.agree_tolerance))
                   && (CMPW'(diff_y) < CMPW'(cfg.agree_tolerance));
    assign pair_x   = {1'b0, fmx_reg} + {1'b0, mx_reg};
    assign pair_y   = {1'b0, fmy_reg} + {1'b0, my_reg};
    assign avg_x    = pair_x[SAMPLE_BITS:1];
    assign avg_y    = pair_y[SAMPLE_BITS:1];

    assign map_avg    = map_axis_reg ? res_reg.coord_y[SAMPLE_BITS-1:0]
                                     : res_reg.coord_x[SAMPLE_BITS-1:0];
    assign map_scale  = map_axis_reg ? cfg.scale_y : cfg.scale_x;
    assign map_offset = map_axis_reg ? cfg.offset_y : cfg.offset_x;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!pen_down)
                    begin
                        state_next = ST_EMIT;
                    end
                    else if (last_sample)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                state_next = ST_RANK;
            end
            ST_RANK:
            begin
                if (j_reg == LAST_IDX)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                state_next = (i_reg == LAST_IDX) ? ST_DIV_GO : ST_LOAD;
            end
            ST_DIV_GO:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = axis_reg ? ST_JUDGE : ST_LOAD;
                end
            end
            ST_JUDGE:
            begin
                if (!second_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (agree_ok && cfg.screen_mode)
                begin
                    state_next = ST_MAP_GO;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_MAP_GO:
            begin
                state_next = ST_MAP_WAIT;
            end
            ST_MAP_WAIT:
            begin
                if (map_done)
                begin
                    state_next = map_axis_reg ? ST_EMIT : ST_MAP_GO;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        div_start = (state_reg == ST_DIV_GO);
        map_start = (state_reg == ST_MAP_GO);
        emit      = (state_reg == ST_EMIT) && out_free;
    end

    // Datapath
    always_comb
    begin
        cnt_next      = cnt_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        rank_next     = rank_reg;
        second_next   = second_reg;
        axis_next     = axis_reg;
        map_axis_next = map_axis_reg;
        fmx_next      = fmx_reg;
        fmy_next      = fmy_reg;
        mx_next       = mx_reg;
        my_next       = my_reg;
        cur_next      = cur_reg;
        sum_next      = sum_reg;
        res_next      = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!pen_down)
                    begin
                        cnt_next    = '0;
                        second_next = 1'b0;
                        res_next    = '0;
                    end
                    else if (last_sample)
                    begin
                        cnt_next  = '0;
                        axis_next = 1'b0;
                        i_next    = '0;
                        sum_next  = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNTW'(1);
                    end
                end
            end
            ST_LOAD:
            begin
                cur_next  = rd_data;
                j_next    = '0;
                rank_next = '0;
            end
            ST_RANK:
            begin
                rank_next = rank_reg + CNTW'(less);
                j_next    = j_reg + CNTW'(1);
            end
            ST_ACC:
            begin
                if (in_keep)
                begin
                    sum_next = sum_reg + SUMW'(cur_reg);
                end
                i_next = i_reg + CNTW'(1);
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (!axis_reg)
                    begin
                        mx_next   = div_q;
                        axis_next = 1'b1;
                        i_next    = '0;
                        sum_next  = '0;
                    end
                    else
                    begin
                        my_next = div_q;
                    end
                end
            end
            ST_JUDGE:
            begin
                if (!second_reg)
                begin
                    fmx_next    = mx_reg;
                    fmy_next    = my_reg;
                    second_next = 1'b1;
                end
                else
                begin
                    second_next          = 1'b0;
                    map_axis_next        = 1'b0;
                    res_next.touched     = 1'b1;
                    res_next.coord_valid = agree_ok;
                    res_next.coord_x     = agree_ok ? COORD_W'(avg_x) : '0;
                    res_next.coord_y     = agree_ok ? COORD_W'(avg_y) : '0;
                end
            end
            ST_MAP_WAIT:
            begin
                if (map_done)
                begin
                    if (!map_axis_reg)
                    begin
                        res_next.coord_x = map_res;
                        map_axis_next    = 1'b1;
                    end
                    else
                    begin
                        res_next.coord_y = map_res;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            second_reg <= 1'b0;
            fmx_reg    <= '0;
            fmy_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            second_reg <= second_next;
            fmx_reg    <= fmx_next;
            fmy_reg    <= fmy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        rank_reg     <= rank_next;
        axis_reg     <= axis_next;
        map_axis_reg <= map_axis_next;
        mx_reg       <= mx_next;
        my_reg       <= my_next;
        cur_reg      <= cur_next;
        sum_reg      <= sum_next;
        res_reg      <= res_next;
    end

    tsfm_div #(
        .SUMW (SUMW),
        .KEPT (KEPT),
        .QW   (SAMPLE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    tsfm_map #(
        .AW (SAMPLE_BITS)
    ) u_map (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (map_start),
        .avg    (map_avg),
        .scale  (map_scale),
        .offset (map_offset),
        .done   (map_done),
        .result (map_res)
    );

    assign res = res_reg;

endmodule

// ===== rtl/touch_sample_filter_and_map.sv =====
// Top level of the touch sample filter and mapper: register file, output
// register and the filter core. Depends on tsfm_pkg and tsfm_core.
//
// Each request is one pen_down flag with an x/y sample pair. A sample that does
// not complete a reading is stored and leaves the block ready for the next
// request; a pen-up request passes through the emit state to place its zero
// result, and waits there while the output register is still full. The sample
// that completes a reading starts a ranking pass per axis through one shared
// comparator and adder, then a divide by the kept count through a reciprocal
// multiply; both axes run in turn, followed by a judge step. After the second
// reading, in screen mode and when the readings agree, each axis is mapped in
// turn; then the result is placed from the emit state, which waits while the
// output register is still full. The block accepts no request during that
// work. A result waits in the output register while the next request is taken.
module touch_sample_filter_and_map #(
    parameter int SAMPLES     = tsfm_pkg::SAMPLES_DEF,
    parameter int TRIM        = tsfm_pkg::TRIM_DEF,
    parameter int SAMPLE_BITS = tsfm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,   // sample_x, sample_y
    input  logic                           s_tuser,   // pen_down
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,   // coord_x, coord_y
    output logic [1:0]                     m_tuser,   // coord_valid, touched
    input  logic                           cfg_wr_en,
    input  logic [tsfm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tsfm_pkg::REG_W-1:0]     cfg_wdata
);
    import tsfm_pkg::*;

    cfg_t cfg_reg, cfg_next;
    res_t res, out_reg;
    logic out_vld_reg, out_vld_next;
    logic out_free, emit;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_SCREEN_MODE: cfg_next.screen_mode     = cfg_wdata[0];
                REG_SWAP_AXES:   cfg_next.swap_axes       = cfg_wdata[0];
                REG_AGREE_TOL:   cfg_next.agree_tolerance = cfg_wdata[TOL_W-1:0];
                REG_SCALE_X:     cfg_next.scale_x         = cfg_wdata;
                REG_SCALE_Y:     cfg_next.scale_y         = cfg_wdata;
                REG_OFFSET_X:    cfg_next.offset_x        = cfg_wdata;
                REG_OFFSET_Y:    cfg_next.offset_y        = cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    assign out_free = !out_vld_reg || m_tready;

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (emit)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_mode     <= 1'b0;
            cfg_reg.swap_axes       <= 1'b0;
            cfg_reg.agree_tolerance <= TOL_RST;
            cfg_reg.scale_x         <= SCALE_RST;
            cfg_reg.scale_y         <= SCALE_RST;
            cfg_reg.offset_x        <= OFFSET_RST;
            cfg_reg.offset_y        <= OFFSET_RST;
            out_vld_reg             <= 1'b0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= res;
        end
    end

    tsfm_core #(
        .SAMPLES     (SAMPLES),
        .TRIM        (TRIM),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .pen_down (s_tuser),
        .sample_x (s_tdata[11:0]),
        .sample_y (s_tdata[23:12]),
        .cfg      (cfg_reg),
        .out_free (out_free),
        .emit     (emit),
        .res      (res)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_reg.coord_y, out_reg.coord_x};
    assign m_tuser  = {out_reg.touched, out_reg.coord_valid};

endmodule

// ===== tb/touch_sample_filter_and_map_tb.sv =====
// Testbench for touch_sample_filter_and_map: streams ADC sample requests and
// checks each coordinate result against a predictor running alongside.
// Depends on tsfm_pkg and the RTL top level only.
module touch_sample_filter_and_map_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsfm_pkg::*;

    localparam int NS          = SAMPLES_DEF;
    localparam int EFF_TRIM    = (2 * TRIM_DEF >= NS) ? (NS - 1) / 2 : TRIM_DEF;
    localparam int KEPT        = NS - 2 * EFF_TRIM;
    localparam logic [IN_W-1:0] SAMPLE_MASK = IN_W'((32'd1 << SAMPLE_BITS_DEF) - 1);
    localparam int SETTLE_CYC  = 300;   // covers two ranking/divide passes plus mapping
    localparam logic [REG_W-1:0] MAX_POS = 32'h7FFF_FFFF;
    localparam logic [REG_W-1:0] MAX_NEG = 32'h8000_0000;

    typedef logic [IN_W-1:0] sample_set_t [NS];

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [23:0]          s_tdata;    // sample_x, sample_y
    logic                 s_tuser;    // pen_down
    logic                 m_tvalid;
    logic                 m_tready;
    logic [31:0]          m_tdata;    // coord_x, coord_y
    logic [1:0]           m_tuser;    // coord_valid, touched
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0]     cfg_wdata;

    // predictor state
    cfg_t          shadow_cfg;
    sample_set_t   filt_x_buf;
    sample_set_t   filt_y_buf;
    int            filt_count;
    bit            filt_second;
    logic [IN_W-1:0] first_avg_x;
    logic [IN_W-1:0] first_avg_y;
    res_t          pending_coords [$];

    int  fail_cnt = 0;
    int  items_sent = 0;
    int  hold_cycles = 0;
    bit  idle_in_en = 1'b1;
    bit  idle_out_en = 1'b1;

    touch_sample_filter_and_map u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("touch_sample_filter_and_map_tb: done, errors");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [IN_W-1:0] trimmed_avg(input sample_set_t src);
        logic [IN_W-1:0] sorted [NS];
        logic [IN_W-1:0] v;
        int              j;
        int unsigned     total;
        total = 0;
        for (int i = 0; i < NS; i++)
        begin
            v = src[i];
            j = i;
            while (j > 0 && sorted[j-1] > v)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        for (int i = EFF_TRIM; i < NS - EFF_TRIM; i++)
            total += sorted[i];
        return IN_W'(total / KEPT);
    endfunction

    function automatic bit within_tol(input logic [IN_W-1:0] a, input logic [IN_W-1:0] b);
        logic [IN_W-1:0] diff;
        diff = (a > b) ? a - b : b - a;
        return diff < shadow_cfg.agree_tolerance;
    endfunction

    // Q16.16 affine map, floor, clamped to 0..65535
    function automatic logic [COORD_W-1:0] map_coord(input logic [IN_W-1:0] avg,
                                                     input logic [REG_W-1:0] scale,
                                                     input logic [REG_W-1:0] offset);
        longint acc;
        acc = longint'($signed(scale)) * longint'(avg) + longint'($signed(offset));
        if (acc < 0)
            return '0;
        if ((acc >>> 16) > 65535)
            return 16'hFFFF;
        return acc[31:16];
    endfunction

    task automatic predict_touch_sample(input bit pen, input logic [IN_W-1:0] sx,
                                        input logic [IN_W-1:0] sy);
        logic [IN_W-1:0] a;
        logic [IN_W-1:0] b;
        logic [IN_W-1:0] mx;
        logic [IN_W-1:0] my;
        logic [IN_W:0]   sum_x;
        logic [IN_W:0]   sum_y;
        res_t            r;
        r = '0;
        if (!pen)
        begin
            filt_count  = 0;
            filt_second = 1'b0;
            pending_coords.push_back(r);
            return;
        end
        a = sx & SAMPLE_MASK;
        b = sy & SAMPLE_MASK;
        if (shadow_cfg.swap_axes)
        begin
            a = sy & SAMPLE_MASK;
            b = sx & SAMPLE_MASK;
        end
        if (filt_count >= NS)
            filt_count = 0;
        filt_x_buf[filt_count] = a;
        filt_y_buf[filt_count] = b;
        filt_count++;
        if (filt_count < NS)
            return;
        filt_count = 0;
        mx = trimmed_avg(filt_x_buf);
        my = trimmed_avg(filt_y_buf);
        if (!filt_second)
        begin
            first_avg_x = mx;
            first_avg_y = my;
            filt_second = 1'b1;
            return;
        end
        filt_second = 1'b0;
        r.touched = 1'b1;
        if (within_tol(first_avg_x, mx) && within_tol(first_avg_y, my))
        begin
            r.coord_valid = 1'b1;
            sum_x = first_avg_x + mx;
            sum_y = first_avg_y + my;
            r.coord_x = COORD_W'(sum_x >> 1);
            r.coord_y = COORD_W'(sum_y >> 1);
            if (shadow_cfg.screen_mode)
            begin
                r.coord_x = map_coord(sum_x[IN_W:1], shadow_cfg.scale_x, shadow_cfg.offset_x);
                r.coord_y = map_coord(sum_y[IN_W:1], shadow_cfg.scale_y, shadow_cfg.offset_y);
            end
        end
        pending_coords.push_back(r);
    endtask

    // ---------------------------------------------------------------- checker

    always @(posedge clk)
    begin : check_coords
        res_t want;
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            if (pending_coords.size() == 0)
            begin
                $error("unexpected result: coord_x %0d coord_y %0d flags %b",
                       m_tdata[15:0], m_tdata[31:16], m_tuser);
                fail_cnt++;
            end
            else
            begin
                want = pending_coords.pop_front();
                if (m_tdata[15:0] !== want.coord_x)
                begin
                    $error("coord_x: expected %0d, got %0d", want.coord_x, m_tdata[15:0]);
                    fail_cnt++;
                end
                if (m_tdata[31:16] !== want.coord_y)
                begin
                    $error("coord_y: expected %0d, got %0d", want.coord_y, m_tdata[31:16]);
                    fail_cnt++;
                end
                if (m_tuser[0] !== want.coord_valid)
                begin
                    $error("coord_valid: expected %0d, got %0d", want.coord_valid, m_tuser[0]);
                    fail_cnt++;
                end
                if (m_tuser[1] !== want.touched)
                begin
                    $error("touched: expected %0d, got %0d", want.touched, m_tuser[1]);
                    fail_cnt++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    initial
    begin : coord_sink
        int n;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                n = hold_cycles;
                hold_cycles = 0;
            end
            else
                n = idle_out_en ? $urandom_range(0, 8) : 0;
            if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (m_tvalid !== 1'b1)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // ---------------------------------------------------------------- sender

    // Called at a falling edge; leaves tvalid high so back-to-back requests
    // never drop it within one step.
    task automatic send_request(input bit pen, input logic [IN_W-1:0] sx,
                                input logic [IN_W-1:0] sy);
        int gap;
        gap = idle_in_en ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {sy, sx};
        s_tuser  <= pen;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        predict_touch_sample(pen, sx, sy);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        wait (pending_coords.size() == 0);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_SCREEN_MODE: shadow_cfg.screen_mode     = val[0];
            REG_SWAP_AXES:   shadow_cfg.swap_axes       = val[0];
            REG_AGREE_TOL:   shadow_cfg.agree_tolerance = val[TOL_W-1:0];
            REG_SCALE_X:     shadow_cfg.scale_x         = val;
            REG_SCALE_Y:     shadow_cfg.scale_y         = val;
            REG_OFFSET_X:    shadow_cfg.offset_x        = val;
            REG_OFFSET_Y:    shadow_cfg.offset_y        = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input bit screen, input bit swap, input logic [TOL_W-1:0] tol,
                              input logic [REG_W-1:0] sc_x, input logic [REG_W-1:0] sc_y,
                              input logic [REG_W-1:0] off_x, input logic [REG_W-1:0] off_y);
        wait_idle();
        write_reg(REG_SCREEN_MODE, REG_W'(screen));
        write_reg(REG_SWAP_AXES, REG_W'(swap));
        write_reg(REG_AGREE_TOL, REG_W'(tol));
        write_reg(REG_SCALE_X, sc_x);
        write_reg(REG_SCALE_Y, sc_y);
        write_reg(REG_OFFSET_X, off_x);
        write_reg(REG_OFFSET_Y, off_y);
    endtask

    function automatic logic [IN_W-1:0] jitter(input int centre, input int spread);
        int v;
        v = centre + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return IN_W'(v);
    endfunction

    function automatic int pick_centre();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 4095;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    // one touch: two readings around a point, sometimes broken by a pen-up
    task automatic send_touch(input int spread);
        int cx;
        int cy;
        cx = pick_centre();
        cy = pick_centre();
        for (int i = 0; i < 2 * NS; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_request(1'b0, IN_W'($urandom), IN_W'($urandom));
            else
                send_request(1'b1, jitter(cx, spread), jitter(cy, spread));
        end
        if ($urandom_range(0, 2) == 0)
            send_request(1'b0, IN_W'($urandom), IN_W'($urandom));
    endtask

    task automatic send_burst(input int n);
        int target;
        target = items_sent + n;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 5) == 0)
                send_request(1'($urandom), IN_W'($urandom), IN_W'($urandom));
            else
                send_touch(($urandom_range(0, 3) == 0) ? 200 : 20);
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_pen_up();
        send_request(1'b0, 12'hFFF, 12'h000);
    endtask

    task automatic test_partial_reading_cleared();
        send_request(1'b1, 12'h123, 12'hABC);
        send_request(1'b1, 12'hFFF, 12'h000);
        send_request(1'b1, 12'h000, 12'hFFF);
        send_request(1'b0, 12'h000, 12'hFFF);
    endtask

    task automatic test_extreme_samples();
        for (int r = 0; r < 2; r++)
            for (int i = 0; i < NS; i++)
                send_request(1'b1, (i % 2 == 0) ? 12'hFFF : 12'h000,
                             (i % 2 == 0) ? 12'h000 : 12'hFFF);
    endtask

    task automatic test_raw_default();
        idle_in_en  = 1'b0;
        idle_out_en = 1'b0;
        set_config(1'b0, 1'b0, TOL_RST, SCALE_RST, SCALE_RST, OFFSET_RST, OFFSET_RST);
        send_burst(30);
        idle_in_en  = 1'b1;
        idle_out_en = 1'b1;
        send_burst(30);
    endtask

    // zero tolerance: nothing can agree
    task automatic test_swapped_never_agree();
        set_config(1'b0, 1'b1, '0, SCALE_RST, SCALE_RST, OFFSET_RST, OFFSET_RST);
        send_burst(40);
    endtask

    task automatic test_screen_identity();
        set_config(1'b1, 1'b0, 12'hFFF, SCALE_RST, SCALE_RST, OFFSET_RST, OFFSET_RST);
        send_burst(60);
    endtask

    task automatic test_screen_saturation();
        set_config(1'b1, 1'b1, 12'd1, MAX_POS, MAX_NEG, MAX_NEG, MAX_POS);
        send_burst(25);
        set_config(1'b1, 1'b0, 12'd400, MAX_NEG, MAX_POS, MAX_POS, MAX_NEG);
        send_burst(25);
    endtask

    task automatic test_screen_random_cal();
        for (int k = 0; k < 4; k++)
        begin
            set_config(1'b1, 1'($urandom), IN_W'($urandom_range(1, 4095)),
                       REG_W'(int'($urandom_range(0, 32'h0020_0000)) - 32'h0008_0000),
                       REG_W'(int'($urandom_range(0, 32'h0020_0000)) - 32'h0008_0000),
                       REG_W'(int'($urandom_range(0, 32'h0400_0000)) - 32'h0100_0000),
                       REG_W'(int'($urandom_range(0, 32'h0400_0000)) - 32'h0100_0000));
            send_burst(18);
        end
    endtask

    // receiver stalls long enough for the output register to fill and block input
    task automatic test_output_backpressure();
        set_config(1'b0, 1'b0, 12'd200, SCALE_RST, SCALE_RST, OFFSET_RST, OFFSET_RST);
        idle_in_en  = 1'b0;
        hold_cycles = 800;
        send_burst(40);
        idle_in_en  = 1'b1;
    endtask

    task automatic test_sender_pause();
        set_config(1'b1, 1'b0, TOL_RST, 32'h0000_1400, 32'h0000_0F00,
                   32'h0001_8000, 32'hFFFF_0000);
        send_burst(30);
        s_tvalid <= 1'b0;
        wait (pending_coords.size() == 0);
        @(negedge clk);
        send_burst(30);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        shadow_cfg = '{screen_mode: 1'b0, swap_axes: 1'b0, agree_tolerance: TOL_RST,
                       scale_x: SCALE_RST, scale_y: SCALE_RST,
                       offset_x: OFFSET_RST, offset_y: OFFSET_RST};
        filt_count  = 0;
        filt_second = 1'b0;
        first_avg_x = '0;
        first_avg_y = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_pen_up();
        test_partial_reading_cleared();
        test_extreme_samples();
        test_raw_default();
        test_swapped_never_agree();
        test_screen_identity();
        test_screen_saturation();
        test_screen_random_cal();
        test_output_backpressure();
        test_sender_pause();

        wait_idle();
        if (fail_cnt == 0)
            $display("touch_sample_filter_and_map_tb: done, clean");
        else
            $display("touch_sample_filter_and_map_tb: done, errors");
        $finish;
    end

endmodule
